// File: hdl/dswd_pkg.sv
package dswd_pkg;

    localparam int MOTOR_COUNT = 2;
    localparam int PACKED_MOTORS = (MOTOR_COUNT < 2) ? MOTOR_COUNT : 2;

    localparam int STEPS_W = 31;
    localparam int PRESCALE_W = 16;
    localparam int PHASE_W = 4;
    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TURN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_OFF = 4'b0000;
    localparam logic [PHASE_W-1:0] PHASE_A = 4'b0001;
    localparam logic [PHASE_W-1:0] PHASE_B = 4'b0010;
    localparam logic [PHASE_W-1:0] PHASE_C = 4'b0100;
    localparam logic [PHASE_W-1:0] PHASE_D = 4'b1000;
    localparam logic [PHASE_W-1:0] PHASE_ALL = 4'b1111;

    localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd1;

    typedef struct packed {
        logic tick;
        logic turn;
        logic stop;
        logic pause;
        logic resume;
        logic reverse;
        logic [STEPS_W-1:0] steps;
    } motor_ctrl_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_next;
        logic [STEPS_W-1:0] steps_next;
    } motor_stat_t;

endpackage

// File: hdl/dswd_motor.sv
module dswd_motor (
    input  logic clk,
    input  logic rst_n,
    input  logic [dswd_pkg::PRESCALE_W-1:0] tick_prescale,
    input  dswd_pkg::motor_ctrl_t ctrl,
    output dswd_pkg::motor_stat_t stat
);

    logic [dswd_pkg::PHASE_W-1:0] phase_reg;
    logic [dswd_pkg::PHASE_W-1:0] phase_next;
    logic [dswd_pkg::STEPS_W-1:0] steps_reg;
    logic [dswd_pkg::STEPS_W-1:0] steps_next;
    logic [dswd_pkg::PRESCALE_W-1:0] count_reg;
    logic [dswd_pkg::PRESCALE_W-1:0] count_next;
    logic [dswd_pkg::PRESCALE_W-1:0] count_dec;
    logic reverse_reg;
    logic reverse_next;
    logic paused_reg;
    logic paused_next;
    logic [dswd_pkg::PHASE_W-1:0] phase_step;

    always_comb
    begin
        case (phase_reg)
            dswd_pkg::PHASE_OFF,
            dswd_pkg::PHASE_A: phase_step = reverse_reg ? dswd_pkg::PHASE_D : dswd_pkg::PHASE_B;
            dswd_pkg::PHASE_B: phase_step = reverse_reg ? dswd_pkg::PHASE_A : dswd_pkg::PHASE_C;
            dswd_pkg::PHASE_C: phase_step = reverse_reg ? dswd_pkg::PHASE_B : dswd_pkg::PHASE_D;
            dswd_pkg::PHASE_D: phase_step = reverse_reg ? dswd_pkg::PHASE_C : dswd_pkg::PHASE_A;
            default:           phase_step = dswd_pkg::PHASE_OFF;
        endcase
    end

    assign count_dec = count_reg - dswd_pkg::PRESCALE_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        steps_next = steps_reg;
        count_next = count_reg;
        reverse_next = reverse_reg;
        paused_next = paused_reg;
        if (ctrl.tick)
        begin
            if ((steps_reg != '0) && !paused_reg)
            begin
                if (count_dec == '0)
                begin
                    count_next = tick_prescale;
                    steps_next = steps_reg - dswd_pkg::STEPS_W'(1);
                    phase_next = phase_step;
                end
                else
                begin
                    count_next = count_dec;
                end
            end
            else
            begin
                phase_next = dswd_pkg::PHASE_OFF;
            end
        end
        if (ctrl.turn)
        begin
            steps_next = ctrl.steps;
            reverse_next = ctrl.reverse;
        end
        if (ctrl.stop)
        begin
            steps_next = '0;
        end
        if (ctrl.pause)
        begin
            paused_next = 1'b1;
        end
        if (ctrl.resume)
        begin
            paused_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dswd_pkg::PHASE_OFF;
            steps_reg <= '0;
            count_reg <= dswd_pkg::PRESCALE_RESET;
            reverse_reg <= 1'b0;
            paused_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            steps_reg <= steps_next;
            count_reg <= count_next;
            reverse_reg <= reverse_next;
            paused_reg <= paused_next;
        end
    end

    assign stat.phase_next = phase_next;
    assign stat.steps_next = steps_next;

    // Only one coil of a motor is ever energized.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(phase_reg))
        else $error("More than one coil energized.");

    // A tick uses at most one step.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.tick |=> (steps_reg == $past(steps_reg))
                   || (steps_reg == $past(steps_reg) - dswd_pkg::STEPS_W'(1)))
        else $error("Tick changed the step count by more than one.");

    // Coils move only on a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.tick |=> phase_reg == $past(phase_reg))
        else $error("Phase changed without a tick.");

endmodule

// File: hdl/dual_stepper_wave_drive.sv
// Wave-drive controller for two four-coil steppers sharing one coil byte.
// Input beats arrive on s_axis: tuser carries the command (tick, turn,
// stop, pause, resume) and the addressed motor, tdata the signed step count
// and the turn direction. Each input beat yields exactly one output beat on
// m_axis with the coil byte, a latch flag that is set when a tick changed
// the byte, the ready mask and the remaining steps of the addressed motor.
// The prescaler reload is written through cfg_we and cfg_wdata; the user
// must do so only while the block is idle, which the block itself does not
// enforce. A value of zero means 65536 ticks per step. Each beat passes the
// input register and then the result register, with the motor updates
// between them. One beat is accepted every cycle as long as the output side
// takes its beats; the result register frees up in the same cycle its beat
// is taken. When the receiver stalls, the result register holds and one
// more beat waits in the input register before s_axis_tready drops.
// Reset clears both motors to zero steps, released coils, forward, not
// paused, prescalers at one, and the reload register to one.
module dual_stepper_wave_drive (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // steps[31:0], direction[32], zero pad
    input  logic [3:0] s_axis_tuser,   // command[2:0], motor[3]
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [47:0] m_axis_tdata,  // coil_byte, ready_mask, remaining_selected, pad
    output logic [0:0] m_axis_tuser    // latch_pulse
);

    logic [dswd_pkg::PRESCALE_W-1:0] prescale_reg;

    logic in_valid_reg;
    logic [dswd_pkg::CMD_W-1:0] in_cmd_reg;
    logic in_motor_reg;
    logic [31:0] in_steps_reg;
    logic in_dir_reg;

    logic out_valid_reg;
    logic [7:0] out_coil_reg;
    logic out_latch_reg;
    logic [1:0] out_ready_reg;
    logic [dswd_pkg::STEPS_W-1:0] out_rem_reg;
    logic [7:0] last_sent_reg;

    logic advance;
    logic accept_in;
    logic is_tick;
    logic [31:0] steps_neg;
    logic [dswd_pkg::STEPS_W-1:0] steps_mag;
    logic reverse_eff;
    logic [7:0] coil_next;
    logic latch_next;
    logic [1:0] ready_next;
    logic [dswd_pkg::STEPS_W-1:0] rem_next;

    dswd_pkg::motor_ctrl_t ctrl [dswd_pkg::MOTOR_COUNT];
    dswd_pkg::motor_stat_t stat [dswd_pkg::MOTOR_COUNT];

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept_in = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= dswd_pkg::PRESCALE_RESET;
        end
        else if (cfg_we)
        begin
            prescale_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_cmd_reg <= s_axis_tuser[2:0];
            in_motor_reg <= s_axis_tuser[3];
            in_steps_reg <= s_axis_tdata[31:0];
            in_dir_reg <= s_axis_tdata[32];
        end
    end

    // A negative count turns the other way; its magnitude saturates.
    assign steps_neg = 32'd0 - in_steps_reg;
    assign reverse_eff = in_dir_reg ^ in_steps_reg[31];
    always_comb
    begin
        if (!in_steps_reg[31])
        begin
            steps_mag = in_steps_reg[30:0];
        end
        else if (steps_neg[31])
        begin
            steps_mag = dswd_pkg::STEPS_MAX;
        end
        else
        begin
            steps_mag = steps_neg[30:0];
        end
    end

    assign is_tick = (in_cmd_reg == dswd_pkg::CMD_TICK);

    for (genvar k = 0; k < dswd_pkg::MOTOR_COUNT; k++)
    begin : g_motor
        logic sel;
        assign sel = advance && (32'(in_motor_reg) == k);
        assign ctrl[k].tick = advance && is_tick;
        assign ctrl[k].turn = sel && (in_cmd_reg == dswd_pkg::CMD_TURN);
        assign ctrl[k].stop = sel && (in_cmd_reg == dswd_pkg::CMD_STOP);
        assign ctrl[k].pause = sel && (in_cmd_reg == dswd_pkg::CMD_PAUSE);
        assign ctrl[k].resume = sel && (in_cmd_reg == dswd_pkg::CMD_RESUME);
        assign ctrl[k].reverse = reverse_eff;
        assign ctrl[k].steps = steps_mag;

        dswd_motor u_motor (
            .clk           (clk),
            .rst_n         (rst_n),
            .tick_prescale (prescale_reg),
            .ctrl          (ctrl[k]),
            .stat          (stat[k])
        );
    end

    always_comb
    begin
        coil_next = '0;
        ready_next = '1;
        for (int k = 0; k < dswd_pkg::PACKED_MOTORS; k++)
        begin
            coil_next[4*k +: 4] = stat[k].phase_next & dswd_pkg::PHASE_ALL;
            ready_next[k] = (stat[k].steps_next == '0);
        end
        if (32'(in_motor_reg) < dswd_pkg::MOTOR_COUNT)
        begin
            rem_next = stat[in_motor_reg].steps_next;
        end
        else
        begin
            rem_next = '0;
        end
        latch_next = is_tick && (coil_next != last_sent_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_sent_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && is_tick)
            begin
                last_sent_reg <= coil_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_coil_reg <= coil_next;
            out_latch_reg <= latch_next;
            out_ready_reg <= ready_next;
            out_rem_reg <= rem_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_rem_reg, out_ready_reg, out_coil_reg};
    assign m_axis_tuser = out_latch_reg;

    // After a tick the last byte sent is the byte just reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_tick) |=> (last_sent_reg == out_coil_reg))
        else $error("Last sent byte does not track the reported coil byte.");

    // Only a tick can raise the latch flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_tick) |=> !out_latch_reg)
        else $error("Latch flag raised by a command other than tick.");

    // An empty result register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("Input stalled while the result register is empty.");

    // A non-tick command leaves the coil byte at the last byte sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_tick) |-> (coil_next == last_sent_reg))
        else $error("Coil byte changed by a command other than tick.");

endmodule
